// ===== rtl/chol_pkg.sv =====
// Shared types, widths and helpers for the 3x3 Cholesky factor pipeline.
// No dependencies; imported by every module in this folder.
package chol_pkg;

    // Number format of every matrix and factor entry.
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Quotient or root bits resolved per pipeline stage in the divider and root units.
    localparam int STEP_BITS = 2;

    // Derived widths of the intermediate values.
    localparam int MAG_W  = WORD_BITS;               // magnitude of one entry
    localparam int PROD_W = 2 * MAG_W;               // product of two magnitudes
    localparam int RIN_W  = MAG_W + FRAC_BITS;       // radicand and factor dividend
    localparam int ROOT_W = RIN_W / 2;               // square root result
    localparam int MT1_W  = PROD_W - 1;              // magnitude of t1
    localparam int R12N_W = MT1_W + FRAC_BITS;       // dividend of u12
    localparam int SQ_W   = 2 * (MAG_W - 1);         // t1 squared when t1 is small

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_P0 = 2'd1,
        ST_BAD_P1 = 2'd2,
        ST_BAD_P2 = 2'd3
    } status_t;

    // Number of pipeline stages needed to resolve the given number of bits.
    function automatic int stages(input int bits);
        return (bits + STEP_BITS - 1) / STEP_BITS;
    endfunction

endpackage

// ===== rtl/chol_div.sv =====
// Pipelined restoring divider, a few quotient bits per stage.
// Depends on chol_pkg for the step size and stage count.
module chol_div
    import chol_pkg::*;
#(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 32
)(
    input  logic                clk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [NUM_BITS-1:0] quo
);

    localparam int NSTG = stages(NUM_BITS);
    localparam int NP   = NSTG * STEP_BITS;

    // Per stage: partial remainder, dividend bits still to go with quotient bits
    // shifted in from the bottom, and the divisor that travels along.
    logic [DEN_BITS-1:0] rem_reg [NSTG];
    logic [NP-1:0]       nq_reg  [NSTG];
    logic [DEN_BITS-1:0] den_reg [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic [DEN_BITS-1:0] rem_in;
        logic [NP-1:0]       nq_in;
        logic [DEN_BITS-1:0] den_in;
        logic [DEN_BITS-1:0] rem_next;
        logic [NP-1:0]       nq_next;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = NP'(num);
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign nq_in  = nq_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        // Each of the STEP_BITS steps shifts in one dividend bit and subtracts the divisor when it fits.
        always_comb
        begin
            logic [DEN_BITS:0] acc;
            rem_next = rem_in;
            nq_next  = nq_in;
            for (int k = 0; k < STEP_BITS; k++)
            begin
                acc     = {rem_next, nq_next[NP-1]};
                nq_next = nq_next << 1;
                if (acc >= {1'b0, den_in})
                begin
                    rem_next   = DEN_BITS'(acc - {1'b0, den_in});
                    nq_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = acc[DEN_BITS-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                nq_reg[g]  <= nq_next;
                den_reg[g] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NSTG-1][NUM_BITS-1:0];

endmodule

// ===== rtl/chol_sqrt.sv =====
// Pipelined digit-by-digit integer square root, a few root bits per stage.
// Depends on chol_pkg for the step size and stage count.
module chol_sqrt
    import chol_pkg::*;
#(
    parameter int IN_BITS = 48
)(
    input  logic                 clk,
    input  logic                 en,
    input  logic [IN_BITS-1:0]   x,
    output logic [IN_BITS/2-1:0] root
);

    localparam int RB   = IN_BITS / 2;
    localparam int NSTG = stages(RB);
    localparam int PB   = NSTG * STEP_BITS;
    localparam int XW   = 2 * PB;
    localparam int RW   = PB + 2;

    // Per stage: remainder, partial root and radicand bits still to go.
    logic [RW-1:0] rem_reg  [NSTG];
    logic [PB-1:0] root_reg [NSTG];
    logic [XW-1:0] x_reg    [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [PB-1:0] root_in;
        logic [XW-1:0] x_in;
        logic [RW-1:0] rem_next;
        logic [PB-1:0] root_next;
        logic [XW-1:0] x_next;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = XW'(x);
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign x_in    = x_reg[g-1];
        end

        // Each of the STEP_BITS steps brings down two radicand bits and tries the next root bit.
        always_comb
        begin
            logic [RW+1:0] acc;
            logic [RW+1:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            x_next    = x_in;
            for (int k = 0; k < STEP_BITS; k++)
            begin
                acc    = {rem_next, x_next[XW-1 -: 2]};
                trial  = {2'b00, root_next, 2'b01};
                x_next = x_next << 2;
                if (acc >= trial)
                begin
                    rem_next  = RW'(acc - trial);
                    root_next = {root_next[PB-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = acc[RW-1:0];
                    root_next = {root_next[PB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                x_reg[g]    <= x_next;
            end
        end
    end

    assign root = root_reg[NSTG-1][RB-1:0];

endmodule

// ===== rtl/chol_dly.sv =====
// Enabled shift line that keeps side values aligned with the arithmetic units.
// Depends on chol_pkg only through the shared import convention.
module chol_dly
    import chol_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] dly_reg [DEPTH];

    // Advance every tap together with the rest of the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

// ===== rtl/cholesky_3x3_factor.sv =====
// Cholesky factor of a symmetric 3x3 Q15.16 matrix, fully pipelined: one matrix beat is
// taken every cycle while the output is not stalled. The pipeline depth is set by the
// longest dependent chain: divisions by s00, then the second square root, then the 79-bit
// division for u12, each resolving two bits per stage. A stalled output freezes the whole
// pipeline; nothing is dropped or repeated. Depends on chol_pkg, chol_div, chol_sqrt, chol_dly.
module cholesky_3x3_factor
    import chol_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] diag_0,
    input  logic signed [WORD_BITS-1:0] diag_1,
    input  logic signed [WORD_BITS-1:0] diag_2,
    input  logic signed [WORD_BITS-1:0] off_01,
    input  logic signed [WORD_BITS-1:0] off_02,
    input  logic signed [WORD_BITS-1:0] off_12,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] u_00,
    output logic signed [WORD_BITS-1:0] u_01,
    output logic signed [WORD_BITS-1:0] u_02,
    output logic signed [WORD_BITS-1:0] u_11,
    output logic signed [WORD_BITS-1:0] u_12,
    output logic signed [WORD_BITS-1:0] u_22,
    output logic [1:0]                  status
);

    // Unit latencies and the cycle at which each value sits in its register.
    localparam int LAT_ROOT   = stages(ROOT_W);
    localparam int LAT_DIVP   = stages(PROD_W);
    localparam int LAT_DIVR   = stages(RIN_W);
    localparam int LAT_DIVR12 = stages(R12N_W);
    localparam int LAT_DIVQ2  = stages(SQ_W);
    localparam int T_PROD     = 2;
    localparam int T_U00      = T_PROD + LAT_ROOT;
    localparam int T_R01      = T_U00 + LAT_DIVR;
    localparam int T_C        = T_PROD + LAT_DIVP + 1;
    localparam int T_U11      = T_C + LAT_ROOT;
    localparam int T_END      = T_U11 + LAT_DIVR12;
    localparam int T_SQ       = T_C + 1;
    localparam int T_T2       = T_SQ + LAT_DIVQ2 + 1;
    localparam int T_U22      = T_T2 + LAT_ROOT;
    localparam int LAT        = T_END + 1;

    localparam int TAGB_W = 5 + 3 * MAG_W;

    function automatic logic [MAG_W-1:0] dec_mag(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? MAG_W'(~v + WORD_BITS'(1)) : MAG_W'(v);
    endfunction

    // Clamp a magnitude to the signed word range and apply the sign.
    function automatic logic [WORD_BITS-1:0] sat_enc(input logic neg,
                                                     input logic [R12N_W-1:0] mag);
        logic [R12N_W-1:0]    lim;
        logic [WORD_BITS-1:0] m;
        lim = R12N_W'({1'b0, {(WORD_BITS-1){1'b1}}}) + R12N_W'(neg);
        m   = (mag > lim) ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
        return neg ? WORD_BITS'(~m + WORD_BITS'(1)) : m;
    endfunction

    // Pipeline control: one enable for every stage, valid bits shift with the data.
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: split every entry into sign and magnitude.
    logic [MAG_W-1:0] d1_m0_reg, d1_m1_reg, d1_m2_reg, d1_m01_reg, d1_m02_reg, d1_m12_reg;
    logic             d1_s0_reg, d1_s1_reg, d1_s2_reg, d1_s01_reg, d1_s02_reg, d1_s12_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_m0_reg  <= dec_mag(diag_0);
            d1_m1_reg  <= dec_mag(diag_1);
            d1_m2_reg  <= dec_mag(diag_2);
            d1_m01_reg <= dec_mag(off_01);
            d1_m02_reg <= dec_mag(off_02);
            d1_m12_reg <= dec_mag(off_12);
            d1_s0_reg  <= diag_0[WORD_BITS-1];
            d1_s1_reg  <= diag_1[WORD_BITS-1];
            d1_s2_reg  <= diag_2[WORD_BITS-1];
            d1_s01_reg <= off_01[WORD_BITS-1];
            d1_s02_reg <= off_02[WORD_BITS-1];
            d1_s12_reg <= off_12[WORD_BITS-1];
        end
    end

    // Stage 2: the three off-diagonal products and the first pivot check.
    logic [PROD_W-1:0] d2_p11_reg, d2_p21_reg, d2_p22_reg;
    logic [MAG_W-1:0]  d2_m0_reg, d2_m1_reg, d2_m2_reg, d2_m01_reg, d2_m02_reg, d2_m12_reg;
    logic              d2_f1_reg, d2_s1_reg, d2_s2_reg, d2_s01_reg, d2_s02_reg, d2_s12_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_p11_reg <= d1_m01_reg * d1_m01_reg;
            d2_p21_reg <= d1_m02_reg * d1_m01_reg;
            d2_p22_reg <= d1_m02_reg * d1_m02_reg;
            d2_m0_reg  <= d1_m0_reg;
            d2_m1_reg  <= d1_m1_reg;
            d2_m2_reg  <= d1_m2_reg;
            d2_m01_reg <= d1_m01_reg;
            d2_m02_reg <= d1_m02_reg;
            d2_m12_reg <= d1_m12_reg;
            d2_f1_reg  <= d1_s0_reg || (d1_m0_reg == '0);
            d2_s1_reg  <= d1_s1_reg;
            d2_s2_reg  <= d1_s2_reg;
            d2_s01_reg <= d1_s01_reg;
            d2_s02_reg <= d1_s02_reg;
            d2_s12_reg <= d1_s12_reg;
        end
    end

    // Quotients by s00 and the first square root.
    logic [PROD_W-1:0] q_quo, p_quo, q1_quo;
    logic [ROOT_W-1:0] u00_root;
    logic [TAGB_W-1:0] tagb;
    logic              tb_s1, tb_s2, tb_s12, tb_s01, tb_s02;
    logic [MAG_W-1:0]  tb_m1, tb_m2, tb_m12;

    chol_div #(.NUM_BITS(PROD_W), .DEN_BITS(MAG_W)) u_div_q (
        .clk(clk), .en(adv), .num(d2_p11_reg), .den(d2_m0_reg), .quo(q_quo)
    );
    chol_div #(.NUM_BITS(PROD_W), .DEN_BITS(MAG_W)) u_div_p (
        .clk(clk), .en(adv), .num(d2_p21_reg), .den(d2_m0_reg), .quo(p_quo)
    );
    chol_div #(.NUM_BITS(PROD_W), .DEN_BITS(MAG_W)) u_div_q1 (
        .clk(clk), .en(adv), .num(d2_p22_reg), .den(d2_m0_reg), .quo(q1_quo)
    );
    chol_sqrt #(.IN_BITS(RIN_W)) u_sqrt0 (
        .clk(clk), .en(adv), .x({d2_m0_reg, {FRAC_BITS{1'b0}}}), .root(u00_root)
    );
    chol_dly #(.WIDTH(TAGB_W), .DEPTH(LAT_DIVP)) u_dly_tagb (
        .clk(clk), .en(adv),
        .din({d2_s1_reg, d2_s2_reg, d2_s12_reg, d2_s01_reg, d2_s02_reg,
              d2_m1_reg, d2_m2_reg, d2_m12_reg}),
        .dout(tagb)
    );
    assign {tb_s1, tb_s2, tb_s12, tb_s01, tb_s02, tb_m1, tb_m2, tb_m12} = tagb;

    // u01 and u02 from the first root.
    logic [2*MAG_W-1:0] m0x_d;
    logic [RIN_W-1:0]   r01_quo, r02_quo;

    chol_dly #(.WIDTH(2 * MAG_W), .DEPTH(LAT_ROOT)) u_dly_m0x (
        .clk(clk), .en(adv), .din({d2_m01_reg, d2_m02_reg}), .dout(m0x_d)
    );
    chol_div #(.NUM_BITS(RIN_W), .DEN_BITS(ROOT_W)) u_div_r01 (
        .clk(clk), .en(adv), .num({m0x_d[2*MAG_W-1:MAG_W], {FRAC_BITS{1'b0}}}),
        .den(u00_root), .quo(r01_quo)
    );
    chol_div #(.NUM_BITS(RIN_W), .DEN_BITS(ROOT_W)) u_div_r02 (
        .clk(clk), .en(adv), .num({m0x_d[MAG_W-1:0], {FRAC_BITS{1'b0}}}),
        .den(u00_root), .quo(r02_quo)
    );

    // Second pivot t0, signed t1 and the first part of the third pivot.
    logic [MT1_W-1:0] c_add_a, c_add_b, c_mt1;
    logic             c_sp, c_st1;
    logic             c_f2_reg, c_st1_reg, c_f3a_reg;
    logic [MAG_W-1:0] c_t0_reg, c_rem_reg;
    logic [MT1_W-1:0] c_mt1_reg;

    always_comb
    begin
        c_add_a = MT1_W'(tb_m12);
        c_add_b = p_quo[MT1_W-1:0];
        c_sp    = (p_quo != '0) && !(tb_s02 ^ tb_s01);
        if (tb_s12 == c_sp)
        begin
            c_mt1 = c_add_a + c_add_b;
            c_st1 = tb_s12;
        end
        else if (c_add_a >= c_add_b)
        begin
            c_mt1 = c_add_a - c_add_b;
            c_st1 = tb_s12;
        end
        else
        begin
            c_mt1 = c_add_b - c_add_a;
            c_st1 = c_sp;
        end
        if (c_mt1 == '0)
        begin
            c_st1 = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_f2_reg  <= tb_s1 || (q_quo >= PROD_W'(tb_m1));
            c_t0_reg  <= tb_m1 - q_quo[MAG_W-1:0];
            c_mt1_reg <= c_mt1;
            c_st1_reg <= c_st1;
            c_f3a_reg <= tb_s2 || (q1_quo >= PROD_W'(tb_m2));
            c_rem_reg <= tb_m2 - q1_quo[MAG_W-1:0];
        end
    end

    // u11 and then u12.
    logic [ROOT_W-1:0] u11_root;
    logic [MT1_W-1:0]  mt1_d;
    logic [R12N_W-1:0] r12_quo;

    chol_sqrt #(.IN_BITS(RIN_W)) u_sqrt1 (
        .clk(clk), .en(adv), .x({c_t0_reg, {FRAC_BITS{1'b0}}}), .root(u11_root)
    );
    chol_dly #(.WIDTH(MT1_W), .DEPTH(LAT_ROOT)) u_dly_mt1 (
        .clk(clk), .en(adv), .din(c_mt1_reg), .dout(mt1_d)
    );
    chol_div #(.NUM_BITS(R12N_W), .DEN_BITS(ROOT_W)) u_div_r12 (
        .clk(clk), .en(adv), .num({mt1_d, {FRAC_BITS{1'b0}}}), .den(u11_root), .quo(r12_quo)
    );

    // t1 squared; a t1 of 2^31 or more always makes the third pivot non-positive.
    logic [SQ_W-1:0]  sq_reg;
    logic [MAG_W-1:0] sq_t0_reg, sq_rem_reg;
    logic             sq_f3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg     <= c_mt1_reg[MAG_W-2:0] * c_mt1_reg[MAG_W-2:0];
            sq_t0_reg  <= c_t0_reg;
            sq_rem_reg <= c_rem_reg;
            sq_f3_reg  <= c_f3a_reg || (c_mt1_reg[MT1_W-1:MAG_W-1] != '0);
        end
    end

    logic [SQ_W-1:0]  q2_quo;
    logic [MAG_W:0]   f3rem_d;

    chol_div #(.NUM_BITS(SQ_W), .DEN_BITS(MAG_W)) u_div_q2 (
        .clk(clk), .en(adv), .num(sq_reg), .den(sq_t0_reg), .quo(q2_quo)
    );
    chol_dly #(.WIDTH(MAG_W + 1), .DEPTH(LAT_DIVQ2)) u_dly_f3rem (
        .clk(clk), .en(adv), .din({sq_f3_reg, sq_rem_reg}), .dout(f3rem_d)
    );

    // Third pivot t2 and its root.
    logic             t2_f3_reg;
    logic [MAG_W-1:0] t2_val_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_f3_reg  <= f3rem_d[MAG_W] || (q2_quo >= SQ_W'(f3rem_d[MAG_W-1:0]));
            t2_val_reg <= f3rem_d[MAG_W-1:0] - q2_quo[MAG_W-1:0];
        end
    end

    logic [ROOT_W-1:0] u22_root;

    chol_sqrt #(.IN_BITS(RIN_W)) u_sqrt2 (
        .clk(clk), .en(adv), .x({t2_val_reg, {FRAC_BITS{1'b0}}}), .root(u22_root)
    );

    // Bring every partial result to the final stage.
    logic [ROOT_W-1:0]  fin_u00, fin_u11, fin_u22;
    logic [2*RIN_W-1:0] fin_r0x;
    logic [2:0]         fin_t2;
    logic [1:0]         fin_tc;
    logic               fin_f3;

    chol_dly #(.WIDTH(ROOT_W), .DEPTH(T_END - T_U00)) u_dly_u00 (
        .clk(clk), .en(adv), .din(u00_root), .dout(fin_u00)
    );
    chol_dly #(.WIDTH(2 * RIN_W), .DEPTH(T_END - T_R01)) u_dly_r0x (
        .clk(clk), .en(adv), .din({r01_quo, r02_quo}), .dout(fin_r0x)
    );
    chol_dly #(.WIDTH(3), .DEPTH(T_END - T_PROD)) u_dly_f1 (
        .clk(clk), .en(adv), .din({d2_f1_reg, d2_s01_reg, d2_s02_reg}), .dout(fin_t2)
    );
    chol_dly #(.WIDTH(2), .DEPTH(T_END - T_C)) u_dly_f2 (
        .clk(clk), .en(adv), .din({c_f2_reg, c_st1_reg}), .dout(fin_tc)
    );
    chol_dly #(.WIDTH(ROOT_W), .DEPTH(T_END - T_U11)) u_dly_u11 (
        .clk(clk), .en(adv), .din(u11_root), .dout(fin_u11)
    );
    chol_dly #(.WIDTH(1), .DEPTH(T_END - T_T2)) u_dly_f3 (
        .clk(clk), .en(adv), .din(t2_f3_reg), .dout(fin_f3)
    );
    chol_dly #(.WIDTH(ROOT_W), .DEPTH(T_END - T_U22)) u_dly_u22 (
        .clk(clk), .en(adv), .din(u22_root), .dout(fin_u22)
    );

    // Final stage: first failing pivot wins, otherwise saturate the quotients.
    status_t              fin_status;
    logic                 fin_zero;
    status_t              status_reg;
    logic [WORD_BITS-1:0] u00_reg, u01_reg, u02_reg, u11_reg, u12_reg, u22_reg;

    always_comb
    begin
        priority if (fin_t2[2])
        begin
            fin_status = ST_BAD_P0;
        end
        else if (fin_tc[1])
        begin
            fin_status = ST_BAD_P1;
        end
        else if (fin_f3)
        begin
            fin_status = ST_BAD_P2;
        end
        else
        begin
            fin_status = ST_OK;
        end
        fin_zero = (fin_status != ST_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_OK;
        end
        else if (adv)
        begin
            status_reg <= fin_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u00_reg <= fin_zero ? '0 : WORD_BITS'(fin_u00);
            u11_reg <= fin_zero ? '0 : WORD_BITS'(fin_u11);
            u22_reg <= fin_zero ? '0 : WORD_BITS'(fin_u22);
            u01_reg <= fin_zero ? '0 : sat_enc(fin_t2[1], R12N_W'(fin_r0x[2*RIN_W-1:RIN_W]));
            u02_reg <= fin_zero ? '0 : sat_enc(fin_t2[0], R12N_W'(fin_r0x[RIN_W-1:0]));
            u12_reg <= fin_zero ? '0 : sat_enc(fin_tc[0], r12_quo);
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign status    = status_reg;
    assign u_00      = u00_reg;
    assign u_01      = u01_reg;
    assign u_02      = u02_reg;
    assign u_11      = u11_reg;
    assign u_12      = u12_reg;
    assign u_22      = u22_reg;

`ifndef SYNTHESIS
    // A failed factorization carries no factor entries.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (u_00 == '0) && (u_01 == '0) && (u_02 == '0) &&
            (u_11 == '0) && (u_12 == '0) && (u_22 == '0))
        else $error("failed factor beat has nonzero entries");

    // Every pivot of a good factorization is at least one code, so its root is positive.
    a_ok_roots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |->
            (u_00 != '0) && !u_00[WORD_BITS-1] && (u_11 != '0) && !u_11[WORD_BITS-1] &&
            (u_22 != '0) && !u_22[WORD_BITS-1])
        else $error("good factor beat has a non-positive diagonal");

    // A held output freezes every valid bit of the pipeline.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while the output was held");
`endif

endmodule

// ===== bench/cholesky_3x3_checker.sv =====
// Scoreboard for cholesky_3x3_factor: predicts the factor of every accepted matrix beat
// and compares it with the result beats. Depends on chol_pkg for widths and status codes.
`timescale 1ns / 100ps

module cholesky_3x3_checker
    import chol_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [WORD_BITS-1:0] diag_0,
    input  logic signed [WORD_BITS-1:0] diag_1,
    input  logic signed [WORD_BITS-1:0] diag_2,
    input  logic signed [WORD_BITS-1:0] off_01,
    input  logic signed [WORD_BITS-1:0] off_02,
    input  logic signed [WORD_BITS-1:0] off_12,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [WORD_BITS-1:0] u_00,
    input  logic signed [WORD_BITS-1:0] u_01,
    input  logic signed [WORD_BITS-1:0] u_02,
    input  logic signed [WORD_BITS-1:0] u_11,
    input  logic signed [WORD_BITS-1:0] u_12,
    input  logic signed [WORD_BITS-1:0] u_22,
    input  logic [1:0]                  status,
    output int                          errors,
    output int                          pending,
    output int                          results_seen
);

    typedef logic [127:0] wide_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t   f00;
        word_t   f01;
        word_t   f02;
        word_t   f11;
        word_t   f12;
        word_t   f22;
        status_t st;
    } factor_t;

    factor_t factor_q[$];

    // Floor of the square root, one root bit at a time from the top.
    function automatic wide_t isqrt(input wide_t n);
        wide_t r;
        wide_t c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (wide_t'(1) << i);
            if (c * c <= n)
                r = c;
        end
        return r;
    endfunction

    // Sign and magnitude to a saturated two's complement word.
    function automatic word_t to_word(input logic neg, input wide_t mag);
        wide_t lim;
        wide_t m;
        lim = neg ? (wide_t'(1) << (WORD_BITS - 1)) : (wide_t'(1) << (WORD_BITS - 1)) - 1;
        m = (mag > lim) ? lim : mag;
        return neg ? word_t'(-m) : word_t'(m);
    endfunction

    function automatic factor_t factorize(input word_t a0, a1, a2, b01, b02, b12);
        factor_t r;
        logic    n0, n1, n2, n01, n02, n12, np, nt1;
        wide_t   m0, m1, m2, m01, m02, m12;
        wide_t   r00, r01, r02, r11, r12, r22, q, t0, p, mt1, q1, rem, q2, t2;
        r = '0;
        n0 = a0[WORD_BITS-1];   m0 = n0 ? wide_t'(-a0) : wide_t'(a0);
        n1 = a1[WORD_BITS-1];   m1 = n1 ? wide_t'(-a1) : wide_t'(a1);
        n2 = a2[WORD_BITS-1];   m2 = n2 ? wide_t'(-a2) : wide_t'(a2);
        n01 = b01[WORD_BITS-1]; m01 = n01 ? wide_t'(-b01) : wide_t'(b01);
        n02 = b02[WORD_BITS-1]; m02 = n02 ? wide_t'(-b02) : wide_t'(b02);
        n12 = b12[WORD_BITS-1]; m12 = n12 ? wide_t'(-b12) : wide_t'(b12);
        // Magnitudes are word-wide; the most negative code has magnitude 2^(W-1).
        m0 &= (wide_t'(1) << WORD_BITS) - 1;  m1 &= (wide_t'(1) << WORD_BITS) - 1;
        m2 &= (wide_t'(1) << WORD_BITS) - 1;  m01 &= (wide_t'(1) << WORD_BITS) - 1;
        m02 &= (wide_t'(1) << WORD_BITS) - 1; m12 &= (wide_t'(1) << WORD_BITS) - 1;

        // First pivot.
        if (n0 || m0 == 0)
        begin
            r.st = ST_BAD_P0;
            return r;
        end
        r00 = isqrt(m0 << FRAC_BITS);
        r01 = (m01 << FRAC_BITS) / r00;
        r02 = (m02 << FRAC_BITS) / r00;

        // Second pivot.
        q = (m01 * m01) / m0;
        if (n1 || q >= m1)
        begin
            r.st = ST_BAD_P1;
            return r;
        end
        t0 = m1 - q;
        r11 = isqrt(t0 << FRAC_BITS);

        // t1 = s12 - s02*s01/s00, kept as sign and magnitude.
        p = (m02 * m01) / m0;
        np = (p == 0) ? 1'b0 : !(n02 ^ n01);
        if (n12 == np)
        begin
            nt1 = n12;
            mt1 = m12 + p;
        end
        else if (m12 >= p)
        begin
            nt1 = n12;
            mt1 = m12 - p;
        end
        else
        begin
            nt1 = np;
            mt1 = p - m12;
        end
        if (mt1 == 0)
            nt1 = 1'b0;
        r12 = (mt1 << FRAC_BITS) / r11;

        // Third pivot, with early outs for a negative s22 or a huge t1.
        if (mt1 >= (wide_t'(1) << 64) || n2)
        begin
            r.st = ST_BAD_P2;
            return r;
        end
        q1 = (m02 * m02) / m0;
        if (q1 >= m2)
        begin
            r.st = ST_BAD_P2;
            return r;
        end
        rem = m2 - q1;
        q2 = (mt1 * mt1) / t0;
        if (q2 >= rem)
        begin
            r.st = ST_BAD_P2;
            return r;
        end
        t2 = rem - q2;
        r22 = isqrt(t2 << FRAC_BITS);

        r.f00 = to_word(1'b0, r00);
        r.f01 = to_word(n01, r01);
        r.f02 = to_word(n02, r02);
        r.f11 = to_word(1'b0, r11);
        r.f12 = to_word(nt1, r12);
        r.f22 = to_word(1'b0, r22);
        r.st  = ST_OK;
        return r;
    endfunction

    task automatic compare_field(input string name, input word_t want, input word_t got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)", $time, name,
                     $signed(want), want, $signed(got), got);
        end
    endtask

    // Predict on every matrix beat, compare on every factor beat.
    always @(posedge clk)
    begin
        factor_t want;
        if (!rst_n)
        begin
            errors = 0;
            results_seen = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                factor_q.insert(factor_q.size(),
                                factorize(diag_0, diag_1, diag_2, off_01, off_02, off_12));
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (factor_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: factor beat with no matrix outstanding", $time);
                end
                else
                begin
                    want = factor_q.pop_front();
                    if (want.st !== status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want.st, status);
                    end
                    compare_field("u_00", want.f00, u_00);
                    compare_field("u_01", want.f01, u_01);
                    compare_field("u_02", want.f02, u_02);
                    compare_field("u_11", want.f11, u_11);
                    compare_field("u_12", want.f12, u_12);
                    compare_field("u_22", want.f22, u_22);
                end
            end
            pending = factor_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the cholesky_3x3_factor bench: clock, reset, matrix stimulus and verdict.
// Depends on chol_pkg, the block and cholesky_3x3_checker.
`timescale 1ns / 100ps

module tb;
    import chol_pkg::*;

    localparam int N_RANDOM = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [WORD_BITS-1:0] diag_0 = '0, diag_1 = '0, diag_2 = '0;
    logic signed [WORD_BITS-1:0] off_01 = '0, off_02 = '0, off_12 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [WORD_BITS-1:0] u_00, u_01, u_02, u_11, u_12, u_22;
    logic [1:0] status;
    int errors, pending, results_seen;
    int matrices_sent = 0;
    bit calm = 1'b0;    // no idling on either side while set

    localparam logic [WORD_BITS-1:0] ONE  = 32'h0001_0000;
    localparam logic [WORD_BITS-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [WORD_BITS-1:0] MINV = 32'h8000_0000;

    always #2 clk = ~clk;

    cholesky_3x3_factor DUT (.*);

    cholesky_3x3_checker scoreboard (.*);

    // Result side stalls at random about ten percent of the time, except while calm is set.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 10);

    // Drive one matrix beat and hold it until it is taken.
    task automatic send_matrix(input logic [WORD_BITS-1:0] a0, a1, a2, b01, b02, b12);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        diag_0 <= a0;
        diag_1 <= a1;
        diag_2 <= a2;
        off_01 <= b01;
        off_02 <= b02;
        off_12 <= b12;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        matrices_sent++;
    endtask

    // Random word with a random magnitude scale, so both small and large codes appear.
    function automatic logic [WORD_BITS-1:0] scaled_word(input int max_shift);
        return $urandom() >> $urandom_range(0, max_shift);
    endfunction

    initial
    begin
        #2000000;
        $display("FAIL cholesky_3x3_factor");
        $finish;
    end

    initial
    begin
        logic [WORD_BITS-1:0] a0, a1, a2, b01, b02, b12;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed matrices: extremes and each way a pivot can fail.
        send_matrix(ONE, ONE, ONE, '0, '0, '0);
        send_matrix('0, ONE, ONE, '0, '0, '0);
        send_matrix(MINV, ONE, ONE, '0, '0, '0);
        send_matrix(MAXV, MAXV, MAXV, '0, '0, '0);
        send_matrix(32'd1, ONE, ONE, MAXV, MINV, '0);
        send_matrix(32'd1, MAXV, MAXV, 32'd0, MINV, MAXV);
        send_matrix(ONE, ONE, ONE, ONE, '0, '0);
        send_matrix(ONE, MINV, ONE, '0, '0, '0);
        send_matrix(ONE, 32'h0002_0000, ONE, ONE, '0, '0);
        send_matrix(ONE, ONE, '0, '0, '0, '0);
        send_matrix(ONE, ONE, MINV, '0, '0, '0);
        send_matrix(ONE, ONE, ONE, '0, ONE, '0);
        send_matrix(MAXV, 32'd1, MAXV, 32'd0, 32'd0, MAXV);
        send_matrix(MAXV, 32'd1, MAXV, 32'd0, 32'd0, MINV);
        send_matrix(32'd1, MAXV, MAXV, 32'd0, 32'd0, 32'd0);
        send_matrix(32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
                    32'hfffe_0000, 32'h0001_0000, 32'hffff_8000);
        send_matrix(32'h0009_0000, 32'h000a_0000, 32'h000e_0000,
                    32'h0003_0000, 32'hfffa_0000, 32'h0002_0000);
        send_matrix(MAXV, MAXV, MAXV, MINV, MAXV, MINV);
        send_matrix(MINV, MINV, MINV, MINV, MINV, MINV);
        send_matrix(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);

        // Random matrices: mostly positive diagonals with smaller off-diagonals, so that
        // most reach the third pivot; the rest are raw words.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 250 && i < 400);
            if ($urandom_range(0, 99) < 75)
            begin
                a0 = scaled_word(20) >> 1;
                a1 = scaled_word(20) >> 1;
                a2 = scaled_word(20) >> 1;
                b01 = scaled_word(30);
                b02 = scaled_word(30);
                b12 = scaled_word(30);
                if (a0 == 0)
                    a0 = ONE;
            end
            else
            begin
                a0 = $urandom();
                a1 = $urandom();
                a2 = $urandom();
                b01 = $urandom();
                b02 = $urandom();
                b12 = $urandom();
            end
            send_matrix(a0, a1, a2, b01, b02, b12);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Sent %0d matrices, checked %0d factor beats, covering all pivot outcomes,",
                 matrices_sent, results_seen);
        $display("saturated quotients, extreme codes and random stalls on both channels.");
        if (errors == 0 && pending == 0)
            $display("PASS cholesky_3x3_factor");
        else
            $display("FAIL cholesky_3x3_factor");
        $finish;
    end

endmodule
